FILE: design/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, token codes and the keyword table for the token scanner.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int ID_CHARS    = 8;
   localparam int VALUE_BITS  = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int KW_COUNT    = 25;

   // token codes
   localparam logic [5:0] TK_EOF    = 6'd0;
   localparam logic [5:0] TK_ERR    = 6'd1;
   localparam logic [5:0] TK_IDENT  = 6'd2;
   localparam logic [5:0] TK_NUM    = 6'd3;
   localparam logic [5:0] TK_KW0    = 6'd4;
   localparam logic [5:0] TK_LPAR   = 6'd29;
   localparam logic [5:0] TK_RPAR   = 6'd30;
   localparam logic [5:0] TK_LBRA   = 6'd31;
   localparam logic [5:0] TK_RBRA   = 6'd32;
   localparam logic [5:0] TK_MUL    = 6'd33;
   localparam logic [5:0] TK_PLUS   = 6'd34;
   localparam logic [5:0] TK_MINUS  = 6'd35;
   localparam logic [5:0] TK_LT     = 6'd36;
   localparam logic [5:0] TK_LE     = 6'd37;
   localparam logic [5:0] TK_GT     = 6'd38;
   localparam logic [5:0] TK_GE     = 6'd39;
   localparam logic [5:0] TK_COLON  = 6'd40;
   localparam logic [5:0] TK_ASSIGN = 6'd41;
   localparam logic [5:0] TK_SEMI   = 6'd42;
   localparam logic [5:0] TK_COMMA  = 6'd43;
   localparam logic [5:0] TK_DOT    = 6'd44;
   localparam logic [5:0] TK_EQ     = 6'd45;
   localparam logic [5:0] TK_NE     = 6'd46;

   typedef struct packed {
      logic [7:0] in_char;
      logic       is_end;
   } req_type;

   typedef struct packed {
      logic [5:0]         token_code;
      logic signed [31:0] number_value;
      logic [63:0]        ident_text;
      logic [7:0]         ident_length;
      logic               last_of_run;
   } rsp_type;

   // token as the scanner front produces it: keyword lookup and sign still to do
   typedef struct packed {
      logic [5:0]            code;
      logic [VALUE_BITS-1:0] value;
      logic                  neg;
      logic [63:0]           text;
      logic [7:0]            len;
      logic                  last;
   } raw_tok_type;

   typedef struct packed {
      logic v0;
      logic v1;
   } push_type;

   typedef struct packed {
      logic not_empty;
      logic room2;
   } qstat_type;

   // string literals sit right-justified, first char in the top used byte
   localparam logic [63:0] KW_RAW [KW_COUNT] = '{
      "program", "begin", "end", "var", "const", "integer", "array",
      "function", "if", "then", "else", "for", "while", "to", "do",
      "downto", "break", "write", "writeln", "readln", "and", "or",
      "div", "mod", "of"
   };

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd7, 4'd5, 4'd3, 4'd3, 4'd5, 4'd7, 4'd5,
      4'd8, 4'd2, 4'd4, 4'd4, 4'd3, 4'd5, 4'd2, 4'd2,
      4'd6, 4'd5, 4'd5, 4'd7, 4'd6, 4'd3, 4'd2,
      4'd3, 4'd3, 4'd2
   };

   // keyword text with the first char in the low byte
   function automatic logic [63:0] kw_text(input int k);
      logic [63:0] r;
      int          n;
      r = '0;
      n = int'(KW_LEN[k]);
      for (int i = 0; i < ID_CHARS; i++) begin
         if (i < n) begin
            r[8*i +: 8] = KW_RAW[k][8*(n-1-i) +: 8];
         end
      end
      return r;
   endfunction

   function automatic raw_tok_type simple_tok(input logic [5:0] code);
      raw_tok_type t;
      t      = '0;
      t.code = code;
      return t;
   endfunction

endpackage

FILE: design/pts_front.sv
// ----------------------------------------------------------------------------
// pts_front
// Character scanner: runs the lexer state machine one char per cycle while
// accept is high and hands up to two raw tokens per item to the token queue.
// ----------------------------------------------------------------------------
module pts_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  pts_pkg::req_type     item,
   output pts_pkg::push_type    push,
   output pts_pkg::raw_tok_type tok0,
   output pts_pkg::raw_tok_type tok1
);

   typedef enum logic [11:0] {
      ST_START   = 12'b0000_0000_0001,
      ST_COMMENT = 12'b0000_0000_0010,
      ST_IDENT   = 12'b0000_0000_0100,
      ST_DEC     = 12'b0000_0000_1000,
      ST_HEX     = 12'b0000_0001_0000,
      ST_OCT     = 12'b0000_0010_0000,
      ST_MINUS   = 12'b0000_0100_0000,
      ST_LESS    = 12'b0000_1000_0000,
      ST_GREATER = 12'b0001_0000_0000,
      ST_COLON   = 12'b0010_0000_0000,
      ST_EQUAL   = 12'b0100_0000_0000,
      ST_BANG    = 12'b1000_0000_0000
   } pts_state_type;

   localparam int VB = pts_pkg::VALUE_BITS;

   pts_state_type state_ff, state_in;
   logic [VB-1:0] accum_ff, accum_in;
   logic          neg_ff, neg_in;
   logic [63:0]   buf_ff, buf_in;
   logic [7:0]    cnt_ff, cnt_in;

   logic [7:0] c;
   logic       fin;
   logic       is_letter, is_digit, is_space, is_alnum, is_eq;
   logic [3:0] dig;

   // start-state decode, independent of the current state
   pts_state_type         sc_state;
   logic                  sc_tv;
   pts_pkg::raw_tok_type  sc_tok;
   logic [VB-1:0]         sc_accum;
   logic [63:0]           sc_buf;
   logic [7:0]            sc_cnt;

   logic                 use_sc, rescan, t0v, t1v;
   pts_pkg::raw_tok_type t0, t1, num_tok, id_tok;

   assign c         = item.in_char;
   assign fin       = item.is_end;
   assign is_letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   assign is_digit  = (c >= "0" && c <= "9");
   assign is_space  = (c == " ") || (c >= 8'h09 && c <= 8'h0D);
   assign is_alnum  = is_letter || is_digit;
   assign is_eq     = !fin && (c == "=");
   assign dig       = c[3:0];

   always_comb begin
      num_tok       = '0;
      num_tok.code  = pts_pkg::TK_NUM;
      num_tok.value = accum_ff;
      num_tok.neg   = neg_ff;
      id_tok        = '0;
      id_tok.code   = pts_pkg::TK_IDENT;
      id_tok.text   = buf_ff;
      id_tok.len    = cnt_ff;
   end

   always_comb begin
      sc_state = ST_START;
      sc_tv    = 1'b0;
      sc_tok   = '0;
      sc_accum = '0;
      sc_buf   = '0;
      sc_cnt   = '0;
      if (fin) begin
         sc_tv  = 1'b1;
         sc_tok = pts_pkg::simple_tok(pts_pkg::TK_EOF);
      end else if (is_space) begin
         sc_state = ST_START;
      end else if (is_letter) begin
         sc_buf   = {56'd0, c};
         sc_cnt   = 8'd1;
         sc_state = ST_IDENT;
      end else if (is_digit) begin
         sc_accum = VB'(dig);
         sc_state = ST_DEC;
      end else begin
         sc_tv = 1'b1;
         case (c)
            "{": begin sc_tv = 1'b0; sc_state = ST_COMMENT; end
            "(": sc_tok = pts_pkg::simple_tok(pts_pkg::TK_LPAR);
            ")": sc_tok = pts_pkg::simple_tok(pts_pkg::TK_RPAR);
            "[": sc_tok = pts_pkg::simple_tok(pts_pkg::TK_LBRA);
            "]": sc_tok = pts_pkg::simple_tok(pts_pkg::TK_RBRA);
            "*": sc_tok = pts_pkg::simple_tok(pts_pkg::TK_MUL);
            "+": sc_tok = pts_pkg::simple_tok(pts_pkg::TK_PLUS);
            ";": sc_tok = pts_pkg::simple_tok(pts_pkg::TK_SEMI);
            ",": sc_tok = pts_pkg::simple_tok(pts_pkg::TK_COMMA);
            ".": sc_tok = pts_pkg::simple_tok(pts_pkg::TK_DOT);
            "-": begin sc_tv = 1'b0; sc_state = ST_MINUS; end
            "<": begin sc_tv = 1'b0; sc_state = ST_LESS; end
            ">": begin sc_tv = 1'b0; sc_state = ST_GREATER; end
            ":": begin sc_tv = 1'b0; sc_state = ST_COLON; end
            "=": begin sc_tv = 1'b0; sc_state = ST_EQUAL; end
            "!": begin sc_tv = 1'b0; sc_state = ST_BANG; end
            "$": begin sc_tv = 1'b0; sc_state = ST_HEX; end
            "&": begin sc_tv = 1'b0; sc_state = ST_OCT; end
            default: sc_tok = pts_pkg::simple_tok(pts_pkg::TK_ERR);
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      accum_in = accum_ff;
      neg_in   = neg_ff;
      buf_in   = buf_ff;
      cnt_in   = cnt_ff;
      t0v      = 1'b0;
      t1v      = 1'b0;
      t0       = '0;
      t1       = '0;
      use_sc   = 1'b0;
      rescan   = 1'b0;
      case (state_ff)
         ST_START: use_sc = 1'b1;
         ST_COMMENT: begin
            if (fin) begin
               t0v      = 1'b1;
               t0       = pts_pkg::simple_tok(pts_pkg::TK_ERR);
               state_in = ST_START;
            end else if (c == "}") begin
               state_in = ST_START;
            end
         end
         ST_IDENT: begin
            if (!fin && is_alnum) begin
               if (cnt_ff < 8'(pts_pkg::ID_CHARS)) begin
                  buf_in[8*cnt_ff[2:0] +: 8] = c;
               end
               if (cnt_ff != 8'hFF) begin
                  cnt_in = cnt_ff + 8'd1;
               end
            end else begin
               t0v    = 1'b1;
               t0     = id_tok;
               rescan = 1'b1;
            end
         end
         ST_DEC: begin
            if (!fin && is_digit) begin
               // x10 as shift-and-add
               accum_in = {accum_ff[VB-4:0], 3'b000} + {accum_ff[VB-2:0], 1'b0}
                          + VB'(dig);
            end else begin
               t0v    = 1'b1;
               t0     = num_tok;
               rescan = 1'b1;
            end
         end
         ST_HEX, ST_OCT: begin
            if (fin || !is_alnum) begin
               t0v    = 1'b1;
               t0     = num_tok;
               rescan = 1'b1;
            end else if (state_ff == ST_HEX && is_digit) begin
               accum_in = {accum_ff[VB-5:0], dig};
            end else if (state_ff == ST_HEX &&
                         ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))) begin
               accum_in = {accum_ff[VB-5:0], dig + 4'd9};
            end else if (state_ff == ST_OCT && c >= "0" && c <= "7") begin
               accum_in = {accum_ff[VB-4:0], dig[2:0]};
            end else begin
               // bad digit: number discarded, char dropped
               t0v      = 1'b1;
               t0       = pts_pkg::simple_tok(pts_pkg::TK_ERR);
               state_in = ST_START;
               accum_in = '0;
               neg_in   = 1'b0;
               buf_in   = '0;
               cnt_in   = '0;
            end
         end
         ST_MINUS: begin
            if (!fin && is_digit) begin
               accum_in = VB'(dig);
               neg_in   = 1'b1;
               state_in = ST_DEC;
            end else begin
               t0v    = 1'b1;
               t0     = pts_pkg::simple_tok(pts_pkg::TK_MINUS);
               rescan = 1'b1;
            end
         end
         ST_LESS: begin
            t0v    = 1'b1;
            t0     = pts_pkg::simple_tok(is_eq ? pts_pkg::TK_LE : pts_pkg::TK_LT);
            rescan = !is_eq;
            state_in = ST_START;
         end
         ST_GREATER: begin
            t0v    = 1'b1;
            t0     = pts_pkg::simple_tok(is_eq ? pts_pkg::TK_GE : pts_pkg::TK_GT);
            rescan = !is_eq;
            state_in = ST_START;
         end
         ST_COLON: begin
            t0v    = 1'b1;
            t0     = pts_pkg::simple_tok(is_eq ? pts_pkg::TK_ASSIGN : pts_pkg::TK_COLON);
            rescan = !is_eq;
            state_in = ST_START;
         end
         ST_BANG: begin
            t0v    = 1'b1;
            t0     = pts_pkg::simple_tok(is_eq ? pts_pkg::TK_NE : pts_pkg::TK_ERR);
            rescan = !is_eq;
            state_in = ST_START;
         end
         ST_EQUAL: begin
            t0v      = 1'b1;
            state_in = ST_START;
            if (!fin && c == "<") begin
               t0 = pts_pkg::simple_tok(pts_pkg::TK_LE);
            end else if (!fin && c == ">") begin
               t0 = pts_pkg::simple_tok(pts_pkg::TK_GE);
            end else begin
               t0     = pts_pkg::simple_tok(pts_pkg::TK_EQ);
               rescan = 1'b1;
            end
         end
         default: use_sc = 1'b1;
      endcase

      // the terminating char goes round again from the start state
      if (use_sc || rescan) begin
         state_in = sc_state;
         accum_in = sc_accum;
         neg_in   = 1'b0;
         buf_in   = sc_buf;
         cnt_in   = sc_cnt;
         if (use_sc) begin
            t0v = sc_tv;
            t0  = sc_tok;
         end else begin
            t1v = sc_tv;
            t1  = sc_tok;
         end
      end

      if (t1v) begin
         t1.last = 1'b1;
      end else begin
         t0.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         accum_ff <= '0;
         neg_ff   <= 1'b0;
         buf_ff   <= '0;
         cnt_ff   <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         accum_ff <= accum_in;
         neg_ff   <= neg_in;
         buf_ff   <= buf_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign push.v0 = accept && t0v;
   assign push.v1 = accept && t1v;
   assign tok0    = t0;
   assign tok1    = t1;

endmodule

FILE: design/pts_queue.sv
// ----------------------------------------------------------------------------
// pts_queue
// Token queue between scanner and back end: two writes, one read per cycle.
// ----------------------------------------------------------------------------
module pts_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  pts_pkg::push_type    push,
   input  pts_pkg::raw_tok_type tok0,
   input  pts_pkg::raw_tok_type tok1,
   input  logic                 pop,
   output pts_pkg::raw_tok_type head,
   output pts_pkg::qstat_type   stat
);

   localparam int PB = pts_pkg::QPTR_BITS;
   localparam int CB = pts_pkg::QCNT_BITS;

   pts_pkg::raw_tok_type slot_ff [pts_pkg::QUEUE_DEPTH];
   logic [PB-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CB-1:0] count_ff, count_in;

   always_comb begin
      wp_in    = wp_ff + PB'(push.v0) + PB'(push.v1);
      rp_in    = rp_ff + PB'(pop);
      count_in = count_ff + CB'(push.v0) + CB'(push.v1) - CB'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.v0) begin
         slot_ff[wp_ff] <= tok0;
      end
      if (push.v1) begin
         slot_ff[wp_ff + PB'(1)] <= tok1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   assign head           = slot_ff[rp_ff];
   assign stat.not_empty = (count_ff != '0);
   assign stat.room2     = (count_ff <= CB'(pts_pkg::QUEUE_DEPTH - 2));

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(pts_pkg::QUEUE_DEPTH))
      else $error("token queue count out of range");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.v0 |-> stat.room2)
      else $error("token written without room for a pair");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.v1 |-> push.v0)
      else $error("second token written without a first");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> stat.not_empty)
      else $error("token read from empty queue");

endmodule

FILE: design/pts_back.sv
// ----------------------------------------------------------------------------
// pts_back
// Token finisher: keyword lookup, number sign, and the result register.
// ----------------------------------------------------------------------------
module pts_back (
   input  logic                 clock,
   input  logic                 reset,
   input  pts_pkg::raw_tok_type head,
   input  pts_pkg::qstat_type   stat,
   output logic                 pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output pts_pkg::rsp_type     rsp_item
);

   logic                           valid_ff;
   pts_pkg::rsp_type               out_ff, out_in;
   logic [5:0]                     code;
   logic [pts_pkg::VALUE_BITS-1:0] mag;

   always_comb begin
      code = head.code;
      for (int k = 0; k < pts_pkg::KW_COUNT; k++) begin
         if (head.code == pts_pkg::TK_IDENT &&
             head.len == 8'(pts_pkg::KW_LEN[k]) &&
             head.text == pts_pkg::kw_text(k)) begin
            code = pts_pkg::TK_KW0 + 6'(k);
         end
      end
   end

   always_comb begin
      // negate at the accumulator width, then sign-extend or cut to 32 bits
      mag                 = head.neg ? -head.value : head.value;
      out_in.token_code   = code;
      out_in.number_value = 32'($signed(mag));
      out_in.ident_text   = head.text;
      out_in.ident_length = head.len;
      out_in.last_of_run  = head.last;
   end

   assign pop = stat.not_empty && (!valid_ff || rsp_pop);

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_item  = out_ff;

endmodule

FILE: design/pascal_token_scanner.sv
// ----------------------------------------------------------------------------
// pascal_token_scanner
// Streaming lexer for a small Pascal subset, one source byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: write one byte (or an end marker, is_end set) per cycle
//   with req_push while req_full is low. Each item gives zero, one or two
//   tokens; the final token of an item has last_of_run set.
//   Result channel: while rsp_empty is low the oldest token sits on
//   rsp_item; pulse rsp_pop to take it.
//   With an idle back end a token enters the token queue at the edge that
//   takes its item and passes from there into the result register; a
//   second token of the same item follows it through the queue.
//   Throughput: one byte per cycle while req_full is low. The scanner
//   state machine closes one char per accepted cycle; the four-entry
//   token queue and the single result register drain one token per cycle
//   while the receiver pops, so an item's second token waits behind its
//   first; req_full rises while the queue has room for fewer than two tokens.
//   Reset (synchronous): scanner returns to the start state with cleared
//   work registers, the queue empties and no result is shown.
//   A stalled receiver holds rsp_item steady; the queue fills and then
//   req_full holds the sender off.
// ----------------------------------------------------------------------------
module pascal_token_scanner (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  pts_pkg::req_type req_item,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output pts_pkg::rsp_type rsp_item
);

   logic                 accept;
   logic                 q_pop;
   pts_pkg::push_type    push;
   pts_pkg::qstat_type   stat;
   pts_pkg::raw_tok_type tok0, tok1, head;

   assign req_full = !stat.room2;
   assign accept   = req_push && !req_full;

   pts_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_item),
      .push   (push),
      .tok0   (tok0),
      .tok1   (tok1)
   );

   pts_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .tok0  (tok0),
      .tok1  (tok1),
      .pop   (q_pop),
      .head  (head),
      .stat  (stat)
   );

   pts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .stat      (stat),
      .pop       (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: tb/pts_checker.sv
// ----------------------------------------------------------------------------
// pts_checker
// Watches both queues of the token scanner, runs a lexer of its own on every
// byte taken and compares each popped token field by field in arrival order.
// ----------------------------------------------------------------------------
module pts_checker
   import pts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  req_type     req_item,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  rsp_type     rsp_item,
   output int          fail_count,
   output int          pending,
   output int          tokens_checked,
   output logic [46:0] codes_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [3:0] {
      LX_START, LX_COMMENT, LX_IDENT, LX_DEC, LX_HEX, LX_OCT, LX_MINUS,
      LX_LESS, LX_GREATER, LX_COLON, LX_EQUAL, LX_BANG
   } lex_state_e;

   string kw_names [KW_COUNT] = '{
      "program", "begin", "end", "var", "const", "integer", "array",
      "function", "if", "then", "else", "for", "while", "to", "do",
      "downto", "break", "write", "writeln", "readln", "and", "or",
      "div", "mod", "of"
   };

   lex_state_e            lx_state;
   logic [VALUE_BITS-1:0] lx_value;
   logic                  lx_neg;
   logic [63:0]           lx_text;
   logic [7:0]            lx_count;

   rsp_type step_tokens[$];
   rsp_type expected_tokens[$];

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic void clear_work();
      lx_value = '0;
      lx_neg   = 1'b0;
      lx_text  = '0;
      lx_count = '0;
   endfunction

   function automatic rsp_type make_token(logic [5:0] code, logic [31:0] value,
                                          logic [63:0] text, logic [7:0] len);
      rsp_type t;
      t              = '0;
      t.token_code   = code;
      t.number_value = value;
      t.ident_text   = text;
      t.ident_length = len;
      return t;
   endfunction

   function automatic void emit_plain(logic [5:0] code);
      step_tokens.push_back(make_token(code, '0, '0, '0));
   endfunction

   function automatic void emit_number();
      logic [VALUE_BITS-1:0] v;
      v = lx_neg ? (~lx_value + 1'b1) : lx_value;
      step_tokens.push_back(make_token(TK_NUM, 32'($signed(v)), '0, '0));
   endfunction

   // case-sensitive keyword match; words longer than eight never match
   function automatic logic [5:0] word_code(logic [63:0] text, logic [7:0] len);
      logic [63:0] w;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (kw_names[k].len() == int'(len)) begin
            w = '0;
            for (int i = 0; i < kw_names[k].len(); i++) w[8*i +: 8] = kw_names[k][i];
            if (w == text) return TK_KW0 + 6'(k);
         end
      end
      return TK_IDENT;
   endfunction

   function automatic void emit_word();
      step_tokens.push_back(make_token(word_code(lx_text, lx_count), '0, lx_text, lx_count));
   endfunction

   function automatic void start_char(logic [7:0] c, logic fin);
      clear_work();
      if (fin) begin
         emit_plain(TK_EOF);
      end else if (is_blank(c)) begin
         lx_state = LX_START;
      end else if (is_letter(c)) begin
         lx_text  = {56'd0, c};
         lx_count = 8'd1;
         lx_state = LX_IDENT;
      end else if (is_digit(c)) begin
         lx_value = c - 8'h30;
         lx_state = LX_DEC;
      end else begin
         case (c)
            "{": lx_state = LX_COMMENT;
            "(": emit_plain(TK_LPAR);
            ")": emit_plain(TK_RPAR);
            "[": emit_plain(TK_LBRA);
            "]": emit_plain(TK_RBRA);
            "*": emit_plain(TK_MUL);
            "+": emit_plain(TK_PLUS);
            ";": emit_plain(TK_SEMI);
            ",": emit_plain(TK_COMMA);
            ".": emit_plain(TK_DOT);
            "-": lx_state = LX_MINUS;
            "<": lx_state = LX_LESS;
            ">": lx_state = LX_GREATER;
            ":": lx_state = LX_COLON;
            "=": lx_state = LX_EQUAL;
            "!": lx_state = LX_BANG;
            "$": lx_state = LX_HEX;
            "&": lx_state = LX_OCT;
            default: emit_plain(TK_ERR);
         endcase
      end
   endfunction

   // second char completes the pair, otherwise the single and a rescan
   function automatic bit close_pair(logic [7:0] c, logic fin, logic [7:0] want,
                                     logic [5:0] pair_code, logic [5:0] single_code);
      lx_state = LX_START;
      if (!fin && c == want) begin
         emit_plain(pair_code);
         return 1'b0;
      end
      emit_plain(single_code);
      return 1'b1;
   endfunction

   // one char in the current state; 1 means scan it again from start
   function automatic bit lex_char(logic [7:0] c, logic fin);
      logic [7:0] d;
      case (lx_state)
         LX_COMMENT: begin
            if (fin) begin
               emit_plain(TK_ERR);
               lx_state = LX_START;
            end else if (c == "}") begin
               lx_state = LX_START;
            end
            return 1'b0;
         end
         LX_IDENT: begin
            if (!fin && (is_letter(c) || is_digit(c))) begin
               if (lx_count < 8'(ID_CHARS)) lx_text[8*lx_count +: 8] = c;
               if (lx_count != 8'd255) lx_count++;
               return 1'b0;
            end
            emit_word();
            clear_work();
            lx_state = LX_START;
            return 1'b1;
         end
         LX_DEC: begin
            if (!fin && is_digit(c)) begin
               lx_value = lx_value * 10 + (c - 8'h30);
               return 1'b0;
            end
            emit_number();
            clear_work();
            lx_state = LX_START;
            return 1'b1;
         end
         LX_HEX, LX_OCT: begin
            if (fin || !(is_letter(c) || is_digit(c))) begin
               emit_number();
               clear_work();
               lx_state = LX_START;
               return 1'b1;
            end
            if (lx_state == LX_HEX) begin
               if (is_digit(c)) d = c - "0";
               else if (c >= "A" && c <= "F") d = c - "A" + 8'd10;
               else if (c >= "a" && c <= "f") d = c - "a" + 8'd10;
               else d = 8'd99;
               if (d < 8'd16) begin
                  lx_value = lx_value * 16 + d;
                  return 1'b0;
               end
            end else if (c >= "0" && c <= "7") begin
               lx_value = lx_value * 8 + (c - 8'h30);
               return 1'b0;
            end
            // bad digit: number thrown away, char dropped
            emit_plain(TK_ERR);
            clear_work();
            lx_state = LX_START;
            return 1'b0;
         end
         LX_MINUS: begin
            if (!fin && is_digit(c)) begin
               lx_value = c - 8'h30;
               lx_neg   = 1'b1;
               lx_state = LX_DEC;
               return 1'b0;
            end
            emit_plain(TK_MINUS);
            lx_state = LX_START;
            return 1'b1;
         end
         LX_LESS:    return close_pair(c, fin, "=", TK_LE, TK_LT);
         LX_GREATER: return close_pair(c, fin, "=", TK_GE, TK_GT);
         LX_COLON:   return close_pair(c, fin, "=", TK_ASSIGN, TK_COLON);
         LX_BANG:    return close_pair(c, fin, "=", TK_NE, TK_ERR);
         LX_EQUAL: begin
            if (!fin && c == "<") begin
               emit_plain(TK_LE);
               lx_state = LX_START;
               return 1'b0;
            end
            return close_pair(c, fin, ">", TK_GE, TK_EQ);
         end
         default: begin
            lx_state = LX_START;
            start_char(c, fin);
            return 1'b0;
         end
      endcase
   endfunction

   function automatic void predict_tokens(req_type it);
      rsp_type t;
      step_tokens = {};
      if (lex_char(it.in_char, it.is_end)) void'(lex_char(it.in_char, it.is_end));
      if (step_tokens.size() > 0) begin
         t             = step_tokens[step_tokens.size()-1];
         t.last_of_run = 1'b1;
         step_tokens[step_tokens.size()-1] = t;
      end
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endfunction

   function automatic void check_token(rsp_type got);
      rsp_type want;
      if (got.token_code <= TK_NE) codes_seen[got.token_code] = 1'b1;
      if (expected_tokens.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: token popped with none expected: code %0d value %0d text %h len %0d",
                     $realtime, got.token_code, got.number_value, got.ident_text,
                     got.ident_length);
         return;
      end
      want = expected_tokens.pop_front();
      tokens_checked++;
      if (got.token_code !== want.token_code || got.number_value !== want.number_value ||
          got.ident_text !== want.ident_text || got.ident_length !== want.ident_length ||
          got.last_of_run !== want.last_of_run) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("%0t: token mismatch", $realtime);
            $display("   expected code %0d value %0d text %h len %0d last %0b",
                     want.token_code, want.number_value, want.ident_text,
                     want.ident_length, want.last_of_run);
            $display("   actual   code %0d value %0d text %h len %0d last %0b",
                     got.token_code, got.number_value, got.ident_text,
                     got.ident_length, got.last_of_run);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         lx_state = LX_START;
         clear_work();
         expected_tokens = {};
         fail_count      = 0;
         tokens_checked  = 0;
         codes_seen      = '0;
      end else begin
         if (rsp_pop && !rsp_empty) check_token(rsp_item);
         if (req_push && !req_full) predict_tokens(req_item);
      end
      pending = expected_tokens.size();
   end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Byte-stream test of the token scanner: a short directed string for the
// corner cases, then random Pascal-like text with noise, bursty input and a
// receiver that stalls; all checking sits in the checker beside the block.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pts_pkg::*;

   localparam int RANDOM_ITEMS = 150;

   typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_e;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    req_push = 1'b0;
   req_type req_item = '0;
   logic    rsp_pop  = 1'b0;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_item;

   int          fail_count;
   int          pending;
   int          tokens_checked;
   logic [46:0] codes_seen;

   int       items_sent  = 0;
   int       blanks_sent = 0;
   int       burst_left  = 0;
   rx_mode_e rx_mode     = RX_STREAM;
   int       rx_phase    = 0;

   string letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
   string alnum   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
   string hex_set = "0123456789abcdefABCDEF";
   string bad_hex = "ghijklmnopqrstuvwxyzGHIJKLMNOPQRSTUVWXYZ";
   string blanks  = " \t\n\v\f\r";
   string kw_list [KW_COUNT] = '{
      "program", "begin", "end", "var", "const", "integer", "array",
      "function", "if", "then", "else", "for", "while", "to", "do",
      "downto", "break", "write", "writeln", "readln", "and", "or",
      "div", "mod", "of"
   };
   string ops [21] = '{
      "(", ")", "[", "]", "*", "+", "-", "<", "<=", ">", ">=", ":", ":=",
      ";", ",", ".", "=", "!=", "=<", "=>", "!"
   };

   pascal_token_scanner u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   pts_checker u_chk (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_item       (req_item),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_item       (rsp_item),
      .fail_count     (fail_count),
      .pending        (pending),
      .tokens_checked (tokens_checked),
      .codes_seen     (codes_seen)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: picks a new stall pattern each time its random phase count runs out
   always @(negedge clock) begin
      if (rx_phase == 0) begin
         rx_mode  = rx_mode_e'($urandom_range(0, 3));
         rx_phase = $urandom_range(20, 120);
      end
      rx_phase--;
      case (rx_mode)
         RX_STREAM: rsp_pop <= 1'b1;
         RX_COIN:   rsp_pop <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_pop <= ($urandom_range(0, 3) == 0);
         default:   rsp_pop <= (rx_phase % 7 == 0);
      endcase
   end

   function automatic logic [7:0] pick_char(string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   // sender works in bursts; a gap between bursts drops push
   task automatic push_byte(input logic [7:0] c, input logic fin);
      req_type it;
      int      gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 3);
         repeat (gap) begin
            @(negedge clock);
            req_push <= 1'b0;
         end
         burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 12);
      end
      burst_left--;
      it.in_char = c;
      it.is_end  = fin;
      @(negedge clock);
      req_push <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
   endtask

   task automatic push_end();
      push_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic push_blank();
      push_byte(pick_char(blanks), 1'b0);
      blanks_sent++;
   endtask

   task automatic push_random_token();
      int    pick;
      int    n;
      int    mut;
      string s;
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
         // keyword, sometimes capitalised, lengthened or clipped
         s   = kw_list[$urandom_range(0, KW_COUNT - 1)];
         mut = $urandom_range(0, 5);
         n   = (mut == 2) ? s.len() - 1 : s.len();
         for (int i = 0; i < n; i++) push_byte((i == 0 && mut == 0) ? s[i] - 8'd32 : s[i], 1'b0);
         if (mut == 1) push_byte(pick_char(alnum), 1'b0);
      end else if (pick < 33) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
         push_byte(pick_char(letters), 1'b0);
         repeat (n - 1) push_byte(pick_char(alnum), 1'b0);
      end else if (pick < 45) begin
         if ($urandom_range(0, 2) == 0) push_byte("-", 1'b0);
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
         repeat (n) push_byte(8'($urandom_range(48, 57)), 1'b0);
      end else if (pick < 53) begin
         push_byte("$", 1'b0);
         repeat ($urandom_range(0, 10)) push_byte(pick_char(hex_set), 1'b0);
         if ($urandom_range(0, 5) == 0) push_byte(pick_char(bad_hex), 1'b0);
      end else if (pick < 60) begin
         push_byte("&", 1'b0);
         repeat ($urandom_range(0, 12)) push_byte(8'($urandom_range(48, 55)), 1'b0);
         if ($urandom_range(0, 5) == 0)
            push_byte($urandom_range(0, 1) ? 8'($urandom_range(56, 57)) : pick_char(letters),
                      1'b0);
      end else if (pick < 80) begin
         push_text(ops[$urandom_range(0, 20)]);
      end else if (pick < 87) begin
         push_byte("{", 1'b0);
         repeat ($urandom_range(0, 6)) begin
            n = $urandom_range(0, 255);
            push_byte((n == 8'h7D) ? 8'h78 : 8'(n), 1'b0);
         end
         push_byte("}", 1'b0);
      end else if (pick < 96) begin
         push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         push_end();
      end
   endtask

   initial begin
      int rand_base;
      int waited;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: end in start and in comment, bang alone, bad hex and octal
      // digits, empty hex, minus number, two-char operators, bytes 0 and 255
      push_end();
      push_text("{x");
      push_end();
      push_text("!a$fG&9$;-7=<=>!=");
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_text("}");
      push_end();

      // one identifier long enough to saturate the length count
      push_byte("q", 1'b0);
      repeat (259) push_byte(pick_char(alnum), 1'b0);
      push_blank();

      rand_base = items_sent - blanks_sent;
      while (items_sent - blanks_sent - rand_base < RANDOM_ITEMS) begin
         push_random_token();
         if ($urandom_range(0, 9) < 6) push_blank();
      end
      push_end();
      @(negedge clock);
      req_push <= 1'b0;

      waited = 0;
      while (pending != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      @(negedge clock);

      $display("%0d bytes scanned, %0d tokens compared, %0d of 47 token codes seen",
               items_sent, tokens_checked, $countones(codes_seen));
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d tokens outstanding", pending);
      $display("status: fail");
      $finish;
   end

endmodule

FILE: filelist.f
design/pts_pkg.sv
design/pts_front.sv
design/pts_queue.sv
design/pts_back.sv
design/pascal_token_scanner.sv
tb/pts_checker.sv
tb/tb.sv
